FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the candidate pool RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Types, constants and encodings of the sorted candidate pool.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int LEN_W      = $clog2(POOL_DEPTH + 1);
    localparam int CFG_W      = 7;
    localparam int EXT_W      = (CFG_W > LEN_W) ? CFG_W : LEN_W;
    localparam int CMD_W      = 2;
    localparam int ID_W       = 32;
    localparam int KEY_W      = 32;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int POS_W      = 6;

    localparam logic [CFG_W-1:0] POOL_LEN_RESET = CFG_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_POP    = 2'd3
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED   = 3'd0,
        STS_NOT_BETTER = 3'd1,
        STS_DUPLICATE  = 3'd2,
        STS_CLEARED    = 3'd3,
        STS_ENTRY      = 3'd4,
        STS_NONE       = 3'd5
    } status_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_DATA,
        ST_INS_LAST,
        ST_INS_FIRST,
        ST_BS_ISSUE,
        ST_BS_CMP,
        ST_DW_ISSUE,
        ST_DW_CMP,
        ST_DF_LEFT,
        ST_DF_RIGHT,
        ST_SH_ISSUE,
        ST_SH_WR,
        ST_POP_CHK,
        ST_RESP
    } state_e;

    typedef struct packed {
        logic              flag;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{flag: 1'b0, key: {KEY_W{1'b1}}, id: '0};

    typedef struct packed {
        logic cand_lt;
        logic entry_lt;
        logic id_eq;
    } cmp_res_t;

endpackage

FILE: src/scp_intf.sv
// ----------------------------------------------------------------------------
// scp channel interfaces
// Valid/ready channels for commands, results and the pool length register.
// ----------------------------------------------------------------------------
interface scp_req_if;
    import scp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   node_id;
    logic [KEY_W-1:0]  dist_key;
    logic [IDX_W-1:0]  entry_index;

    modport source (output valid, cmd, node_id, dist_key, entry_index, input ready);
    modport sink   (input valid, cmd, node_id, dist_key, entry_index, output ready);
endinterface

interface scp_rsp_if;
    import scp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [ID_W-1:0]      out_id;
    logic [KEY_W-1:0]     out_dist;
    logic                 out_flag;

    modport source (output valid, status, position, out_id, out_dist, out_flag,
                    input ready);
    modport sink   (input valid, status, position, out_id, out_dist, out_flag,
                    output ready);
endinterface

interface scp_cfg_if;
    import scp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  pool_len;

    modport source (output valid, pool_len, input ready);
    modport sink   (input valid, pool_len, output ready);
endinterface

FILE: src/scp_ram.sv
// ----------------------------------------------------------------------------
// scp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/scp_cmp.sv
// ----------------------------------------------------------------------------
// scp_cmp
// Shared key/id comparator between a pool entry and the held candidate.
// ----------------------------------------------------------------------------
module scp_cmp (
    input  scp_pkg::entry_t          entry,
    input  logic [scp_pkg::KEY_W-1:0] cand_key,
    input  logic [scp_pkg::ID_W-1:0]  cand_id,
    output scp_pkg::cmp_res_t        res
);
    import scp_pkg::*;

    always_comb
    begin
        res.cand_lt  = cand_key < entry.key;
        res.entry_lt = entry.key < cand_key;
        res.id_eq    = entry.id == cand_id;
    end

endmodule

FILE: src/sorted_candidate_pool.sv
// ----------------------------------------------------------------------------
// sorted_candidate_pool
// Ascending-key candidate pool: insert, clear, read entry, pop unexpanded.
// ----------------------------------------------------------------------------
// channel | dir | transfer moves
// req     | in  | cmd, node_id, dist_key, entry_index
// rsp     | out | status, position, out_id, out_dist, out_flag
// cfg     | in  | pool_len
//
// One command at a time, all entries in one RAM with one read and one write
// port; every step is one RAM access, and the result is then handed off.
// Read fetches one entry. Pop scans entries from index 0. Insert ends if not
// better than the last entry, shifts entries up for a new first entry, and
// otherwise runs a binary search, walks entries for duplicates, shifts up.
// Clear writes every entry, as does the pass after reset (req not ready).
// Result register lets the next command start while rsp is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_candidate_pool (
    input  logic clk,
    input  logic rst_n,
    scp_req_if.sink   req,
    scp_rsp_if.source rsp,
    scp_cfg_if.sink   cfg
);
    import scp_pkg::*;

    state_e                state_reg, state_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [ADDR_W-1:0]     left_reg, left_next;
    logic [ADDR_W-1:0]     right_reg, right_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  clr_resp_reg, clr_resp_next;
    logic [CFG_W-1:0]      pool_len_reg;

    status_e               res_status_reg, res_status_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic [KEY_W-1:0]      res_dist_reg, res_dist_next;
    logic                  res_flag_reg, res_flag_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    status_e               rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]      rsp_pos_reg, rsp_pos_next;
    logic [ID_W-1:0]       rsp_id_reg, rsp_id_next;
    logic [KEY_W-1:0]      rsp_dist_reg, rsp_dist_next;
    logic                  rsp_flag_reg, rsp_flag_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    entry_t                ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd;
    cmp_res_t              cmp;

    logic [EXT_W-1:0]      len_ext;
    logic [EXT_W-1:0]      len_used;
    logic [ADDR_W-1:0]     last_idx;
    logic [ADDR_W:0]       mid_sum;
    logic [ADDR_W-1:0]     mid;
    logic                  bs_more;
    logic                  req_ready;

    scp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = entry_t'(ram_rdata);

    scp_cmp u_cmp (
        .entry    (rd),
        .cand_key (key_reg),
        .cand_id  (id_reg),
        .res      (cmp)
    );

    always_comb
    begin
        len_ext = EXT_W'(pool_len_reg);
        if (len_ext == '0)
        begin
            len_used = EXT_W'(1);
        end
        else if (len_ext > EXT_W'(POOL_DEPTH))
        begin
            len_used = EXT_W'(POOL_DEPTH);
        end
        else
        begin
            len_used = len_ext;
        end
        last_idx = ADDR_W'(len_used - EXT_W'(1));
        mid_sum  = (ADDR_W + 1)'(left_reg) + (ADDR_W + 1)'(right_reg);
        mid      = mid_sum[ADDR_W:1];
        bs_more  = ((ADDR_W + 1)'(left_reg) + (ADDR_W + 1)'(1)) < (ADDR_W + 1)'(right_reg);
    end

    assign cfg.ready     = 1'b1;
    assign req.ready     = req_ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.position  = rsp_pos_reg;
    assign rsp.out_id    = rsp_id_reg;
    assign rsp.out_dist  = rsp_dist_reg;
    assign rsp.out_flag  = rsp_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pool_len_reg  <= POOL_LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            clr_resp_reg  <= clr_resp_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                pool_len_reg <= cfg.pool_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        right_reg      <= right_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_id_reg     <= res_id_next;
        res_dist_reg   <= res_dist_next;
        res_flag_reg   <= res_flag_next;
        rsp_status_reg <= rsp_status_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_dist_reg   <= rsp_dist_next;
        rsp_flag_reg   <= rsp_flag_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        clr_resp_next   = clr_resp_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_id_next     = res_id_reg;
        res_dist_next   = res_dist_reg;
        res_flag_next   = res_flag_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_dist_next   = rsp_dist_reg;
        rsp_flag_next   = rsp_flag_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ENTRY_RESET;
        ram_raddr       = ptr_reg;
        req_ready       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ENTRY_RESET;
                ptr_next  = ptr_reg + ADDR_W'(1);
                if (ptr_reg == ADDR_W'(POOL_DEPTH - 1))
                begin
                    ptr_next = '0;
                    if (clr_resp_reg)
                    begin
                        res_status_next = STS_CLEARED;
                        res_pos_next    = '0;
                        res_id_next     = '0;
                        res_dist_next   = '0;
                        res_flag_next   = 1'b0;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    id_next  = req.node_id;
                    key_next = req.dist_key;
                    idx_next = req.entry_index;
                    unique case (cmd_e'(req.cmd))
                        CMD_INSERT:
                        begin
                            ram_raddr  = last_idx;
                            state_next = ST_INS_LAST;
                        end
                        CMD_CLEAR:
                        begin
                            ptr_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            if (32'(req.entry_index) < 32'(POOL_DEPTH))
                            begin
                                ram_raddr  = ADDR_W'(req.entry_index);
                                state_next = ST_RD_DATA;
                            end
                            else
                            begin
                                res_status_next = STS_ENTRY;
                                res_pos_next    = POS_W'(req.entry_index);
                                res_id_next     = '0;
                                res_dist_next   = '0;
                                res_flag_next   = 1'b0;
                                state_next      = ST_RESP;
                            end
                        end
                        CMD_POP:
                        begin
                            ptr_next   = '0;
                            ram_raddr  = '0;
                            state_next = ST_POP_CHK;
                        end
                    endcase
                end
            end

            ST_RD_DATA:
            begin
                res_status_next = STS_ENTRY;
                res_pos_next    = POS_W'(idx_reg);
                res_id_next     = rd.id;
                res_dist_next   = rd.key;
                res_flag_next   = rd.flag;
                state_next      = ST_RESP;
            end

            ST_INS_LAST:
            begin
                if (!cmp.cand_lt)
                begin
                    res_status_next = STS_NOT_BETTER;
                    res_pos_next    = '0;
                    res_id_next     = '0;
                    res_dist_next   = '0;
                    res_flag_next   = 1'b0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = ST_INS_FIRST;
                end
            end

            ST_INS_FIRST:
            begin
                if (cmp.cand_lt)
                begin
                    right_next = '0;
                    ptr_next   = last_idx;
                    state_next = ST_SH_ISSUE;
                end
                else
                begin
                    left_next  = '0;
                    right_next = last_idx;
                    state_next = ST_BS_ISSUE;
                end
            end

            ST_BS_ISSUE:
            begin
                if (bs_more)
                begin
                    ram_raddr  = mid;
                    state_next = ST_BS_CMP;
                end
                else
                begin
                    state_next = ST_DW_ISSUE;
                end
            end

            ST_BS_CMP:
            begin
                if (cmp.cand_lt)
                begin
                    right_next = mid;
                end
                else
                begin
                    left_next = mid;
                end
                state_next = ST_BS_ISSUE;
            end

            ST_DW_ISSUE:
            begin
                ram_raddr = left_reg;
                if (left_reg != '0)
                begin
                    state_next = ST_DW_CMP;
                end
                else
                begin
                    state_next = ST_DF_LEFT;
                end
            end

            ST_DW_CMP, ST_DF_LEFT:
            begin
                if (cmp.id_eq)
                begin
                    res_status_next = STS_DUPLICATE;
                    res_pos_next    = '0;
                    res_id_next     = '0;
                    res_dist_next   = '0;
                    res_flag_next   = 1'b0;
                    state_next      = ST_RESP;
                end
                else if (state_reg == ST_DW_CMP && !cmp.entry_lt)
                begin
                    left_next  = left_reg - ADDR_W'(1);
                    state_next = ST_DW_ISSUE;
                end
                else
                begin
                    ram_raddr  = right_reg;
                    state_next = ST_DF_RIGHT;
                end
            end

            ST_DF_RIGHT:
            begin
                if (cmp.id_eq)
                begin
                    res_status_next = STS_DUPLICATE;
                    res_pos_next    = '0;
                    res_id_next     = '0;
                    res_dist_next   = '0;
                    res_flag_next   = 1'b0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ptr_next   = last_idx;
                    state_next = ST_SH_ISSUE;
                end
            end

            ST_SH_ISSUE:
            begin
                if (ptr_reg > right_reg)
                begin
                    ram_raddr  = ptr_reg - ADDR_W'(1);
                    state_next = ST_SH_WR;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = right_reg;
                    ram_wdata       = '{flag: 1'b1, key: key_reg, id: id_reg};
                    res_status_next = STS_INSERTED;
                    res_pos_next    = POS_W'(right_reg);
                    res_id_next     = '0;
                    res_dist_next   = '0;
                    res_flag_next   = 1'b0;
                    state_next      = ST_RESP;
                end
            end

            ST_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = rd;
                ptr_next   = ptr_reg - ADDR_W'(1);
                state_next = ST_SH_ISSUE;
            end

            ST_POP_CHK:
            begin
                if (rd.flag)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = ptr_reg;
                    ram_wdata       = '{flag: 1'b0, key: rd.key, id: rd.id};
                    res_status_next = STS_ENTRY;
                    res_pos_next    = POS_W'(ptr_reg);
                    res_id_next     = rd.id;
                    res_dist_next   = rd.key;
                    res_flag_next   = 1'b1;
                    state_next      = ST_RESP;
                end
                else if (ptr_reg == last_idx)
                begin
                    res_status_next = STS_NONE;
                    res_pos_next    = '0;
                    res_id_next     = '0;
                    res_dist_next   = '0;
                    res_flag_next   = 1'b0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ptr_next  = ptr_reg + ADDR_W'(1);
                    ram_raddr = ptr_reg + ADDR_W'(1);
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_pos_next    = res_pos_reg;
                    rsp_id_next     = res_id_reg;
                    rsp_dist_next   = res_dist_reg;
                    rsp_flag_next   = res_flag_reg;
                    clr_resp_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_busy_after_req, clk, rst_n, (req.valid && req.ready) |=> !req.ready, "req accepted while a command is in progress")
    `ASSERT_CLK(a_search_order, clk, rst_n, (state_reg == ST_BS_ISSUE) |-> (left_reg < right_reg), "binary search bounds crossed")
    `ASSERT_CLK(a_shift_bound, clk, rst_n, (state_reg == ST_SH_WR) |-> (ptr_reg > right_reg), "shift went below the insert position")
    `ASSERT_CLK(a_pop_bound, clk, rst_n, (state_reg == ST_POP_CHK) |-> (ptr_reg <= last_idx), "pop scan beyond pool length")
    `ASSERT_ALWAYS(a_idle_no_write, clk, (state_reg == ST_IDLE) |-> !ram_we, "pool RAM written while idle")

endmodule
